// ===== hw/rtl/sso_pkg.sv =====
// Shared types, constants and helper functions for the skid-steer odometry block.
package sso_pkg;

  typedef struct packed {
    logic signed [23:0] rpm_front_left;
    logic signed [23:0] rpm_front_right;
    logic signed [23:0] rpm_rear_left;
    logic signed [23:0] rpm_rear_right;
    logic [31:0]        timestamp_us;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] fwd_speed;
    logic signed [31:0] yaw_rate;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [15:0]        heading;
  } out_item_t;

  typedef struct packed {
    logic [15:0]        wheel_radius_q16;
    logic [15:0]        gear_ratio_q16;
    logic [23:0]        inv_baseline_q16;
    logic               integration_method;
    logic signed [31:0] initial_x;
    logic signed [31:0] initial_y;
    logic [15:0]        initial_heading;
  } cfg_t;

  typedef struct packed {
    logic signed [25:0] sum_s;
    logic signed [25:0] sum_d;
    logic [31:0]        dt;
    logic               first;
  } fe_item_t;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_RADIUS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GEAR_RATIO     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_BASELINE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_METHOD   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_X      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_Y      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_HEAD   = 3'd6;

  localparam logic [20:0] TWO_PI_OVER_60_Q24 = 21'd1756906;
  localparam logic [29:0] INV_TWO_PI_Q32     = 30'd683565276;
  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic [20:0] USEC_PER_SEC       = 21'd1000000;
  localparam logic [63:0] HALF_SEC_US        = 64'd500000;
  // ceil(2^52 / 10^6): exact quotient of any 32-bit value by 10^6 after a shift by 52
  localparam logic [32:0] DIV_RECIP          = 33'd4503599628;
  // twelve quotient bits a cycle over a 72-bit numerator
  localparam int          DIV_CYCLES         = 6;

  function automatic logic [29:0] atan_turn(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/skid_steer_odometry.sv =====
// Top level: configuration registers, front end, queue and back end.
// The back end takes one request at a time from the queue and holds it while the output stalls;
// each request makes two passes of the shared reciprocal divider by 10^6 and one run of the
// iterative CORDIC before the back end takes the next.
// The queue holds two requests, so the input is taken while a result waits.
// Synchronous active-low reset clears pose, time base and configuration.
module skid_steer_odometry #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  sso_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output sso_pkg::out_item_t              out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sso_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                     cfg_data
);
  import sso_pkg::*;

  cfg_t     cfg_r;
  fe_item_t push_item, pop_item;
  logic     q_push, q_pop, q_full, q_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WHEEL_RADIUS: cfg_r.wheel_radius_q16   <= cfg_data[15:0];
        CFG_GEAR_RATIO:   cfg_r.gear_ratio_q16     <= cfg_data[15:0];
        CFG_INV_BASELINE: cfg_r.inv_baseline_q16   <= cfg_data[23:0];
        CFG_INTEG_METHOD: cfg_r.integration_method <= cfg_data[0];
        CFG_INITIAL_X:    cfg_r.initial_x          <= cfg_data;
        CFG_INITIAL_Y:    cfg_r.initial_y          <= cfg_data;
        CFG_INITIAL_HEAD: cfg_r.initial_heading    <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  sso_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (push_item)
  );

  sso_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .full      (q_full),
    .empty     (q_empty)
  );

  sso_back #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_item    (pop_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== hw/rtl/sso_front.sv =====
// Front end: accepts wheel requests, forms side sums and elapsed time.
module sso_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  sso_pkg::in_item_t in_data,
  input  logic             q_full,
  output logic             q_push,
  output sso_pkg::fe_item_t q_item
);
  import sso_pkg::*;

  logic        first_r, first_nxt;
  logic [31:0] last_time_r, last_time_nxt;
  logic signed [24:0] left, right;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  assign left  = {in_data.rpm_front_left[23], in_data.rpm_front_left}
               + {in_data.rpm_rear_left[23], in_data.rpm_rear_left};
  assign right = {in_data.rpm_front_right[23], in_data.rpm_front_right}
               + {in_data.rpm_rear_right[23], in_data.rpm_rear_right};

  always_comb begin
    q_item.sum_s = {right[24], right} - {left[24], left};
    q_item.sum_d = {right[24], right} + {left[24], left};
    q_item.dt    = first_r ? 32'd0 : in_data.timestamp_us - last_time_r;
    q_item.first = first_r;
    first_nxt     = q_push ? 1'b0 : first_r;
    last_time_nxt = q_push ? in_data.timestamp_us : last_time_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r     <= 1'b1;
      last_time_r <= 32'd0;
    end else begin
      first_r     <= first_nxt;
      last_time_r <= last_time_nxt;
    end
  end

endmodule

// ===== hw/rtl/sso_queue.sv =====
// Two-entry queue between the front end and the arithmetic back end.
module sso_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sso_pkg::fe_item_t push_item,
  input  logic              pop,
  output sso_pkg::fe_item_t pop_item,
  output logic              full,
  output logic              empty
);
  import sso_pkg::*;

  fe_item_t   mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign pop_item = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== hw/rtl/sso_back.sv =====
// Back end: speed scaling, shared divider, CORDIC and pose integration.
module sso_back #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sso_pkg::cfg_t      cfg,
  input  logic               q_empty,
  output logic               q_pop,
  input  sso_pkg::fe_item_t  q_item,
  output logic               out_valid,
  input  logic               out_stall,
  output sso_pkg::out_item_t out_data
);
  import sso_pkg::*;

  localparam int CNT_W = $clog2(CORDIC_STEPS);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_W    = 4'd1;
  localparam logic [3:0] ST_C    = 4'd2;
  localparam logic [3:0] ST_L    = 4'd3;
  localparam logic [3:0] ST_Y    = 4'd4;
  localparam logic [3:0] ST_P1   = 4'd5;
  localparam logic [3:0] ST_D1   = 4'd6;
  localparam logic [3:0] ST_T    = 4'd7;
  localparam logic [3:0] ST_T2   = 4'd8;
  localparam logic [3:0] ST_CR   = 4'd9;
  localparam logic [3:0] ST_CF   = 4'd10;
  localparam logic [3:0] ST_P2   = 4'd11;
  localparam logic [3:0] ST_D2   = 4'd12;
  localparam logic [3:0] ST_M    = 4'd13;
  localparam logic [3:0] ST_U    = 4'd14;

  logic [3:0]          state_r;
  fe_item_t            item_r;
  logic [31:0]         w_r;
  logic [21:0]         c_r;
  logic signed [31:0]  lin_r, dv_r, yaw_r;
  logic [43:0]         m_r;
  logic [23:0]         pa_r;
  logic [54:0]         pb_r;
  logic [31:0]         full_r;
  logic signed [33:0]  cx_r, cy_r;
  logic signed [32:0]  cz_r;
  logic                flip_r;
  logic [CNT_W-1:0]    cnt_r;
  logic signed [17:0]  co_r, si_r;
  logic signed [44:0]  dist_r;
  logic signed [62:0]  dxp_r, dyp_r;
  logic signed [31:0]  cur_x_r, cur_y_r;
  logic [15:0]         cur_hd_r;
  logic                out_valid_r;
  out_item_t           out_data_r;

  logic [71:0] div_num_r, div_num_nxt;
  logic [19:0] div_rem_r, div_rem_nxt;
  logic [43:0] div_q_r, div_q_nxt;
  logic [4:0]  div_cnt_r;
  logic [31:0] div_x, div_sub;
  logic [63:0] div_prod;
  logic [11:0] div_digit;

  logic [53:0]        c_sum;
  logic signed [48:0] lin_p, dv_p, lin_rs, dv_rs;
  logic signed [56:0] yaw_p, yaw_rs;
  logic [31:0]        yaw_mag, lin_mag;
  logic [48:0]        p49;
  logic [49:0]        full_t, half_t;
  logic [31:0]        full_v, half_v, base, ang;
  logic signed [32:0] z0;
  logic signed [33:0] dxs, dys;
  logic signed [32:0] at;
  logic signed [33:0] xr_s, yr_s;
  logic signed [19:0] xr, yr;
  logic signed [17:0] xc, yc;
  logic signed [46:0] dx, dy;
  logic signed [47:0] nx, ny;
  logic [31:0]        hd_sum;
  logic               out_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign q_pop     = (state_r == ST_IDLE) && !q_empty;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    div_x       = {div_rem_r, div_num_r[71:60]};
    div_prod    = 64'(div_x) * 64'(DIV_RECIP);
    div_digit   = div_prod[63:52];
    div_sub     = div_x - 32'(div_digit) * 32'(USEC_PER_SEC);
    div_rem_nxt = div_sub[19:0];
    div_num_nxt = {div_num_r[59:0], 12'd0};
    div_q_nxt   = {div_q_r[31:0], div_digit};
  end

  always_comb begin
    c_sum   = 54'(w_r) * 54'(TWO_PI_OVER_60_Q24) + 54'h80000000;
    lin_p   = item_r.sum_s * $signed({1'b0, c_r});
    dv_p    = item_r.sum_d * $signed({1'b0, c_r});
    lin_rs  = (lin_p + 49'sd131072) >>> 18;
    dv_rs   = (dv_p + 49'sd65536) >>> 17;
    yaw_p   = dv_r * $signed({1'b0, cfg.inv_baseline_q16});
    yaw_rs  = (yaw_p + 57'sd32768) >>> 16;
    yaw_mag = yaw_r[31] ? 32'd0 - yaw_r : yaw_r;
    lin_mag = lin_r[31] ? 32'd0 - lin_r : lin_r;

    p49    = 49'({pa_r, 25'd0}) + pb_r[48:0];
    full_t = {1'b0, p49} + 50'h8000;
    half_t = {1'b0, p49} + 50'h10000;
    full_v = yaw_r[31] ? 32'd0 - full_t[47:16] : full_t[47:16];
    half_v = yaw_r[31] ? 32'd0 - half_t[48:17] : half_t[48:17];
    base   = {cur_hd_r, 16'd0};
    ang    = cfg.integration_method ? base + half_v : base;
    z0     = $signed({ang[31], ang});

    dxs = cy_r >>> cnt_r;
    dys = cx_r >>> cnt_r;
    at  = $signed({3'b000, atan_turn(5'(cnt_r))});

    xr_s = (cx_r + 34'sd8192) >>> 14;
    yr_s = (cy_r + 34'sd8192) >>> 14;
    xr   = xr_s[19:0];
    yr   = yr_s[19:0];
    if (xr > 20'sd65536) begin
      xc = 18'sd65536;
    end else if (xr < -20'sd65536) begin
      xc = -18'sd65536;
    end else begin
      xc = xr[17:0];
    end
    if (yr > 20'sd65536) begin
      yc = 18'sd65536;
    end else if (yr < -20'sd65536) begin
      yc = -18'sd65536;
    end else begin
      yc = yr[17:0];
    end

    dx     = 47'((dxp_r + 63'sd32768) >>> 16);
    dy     = 47'((dyp_r + 63'sd32768) >>> 16);
    nx     = {{16{cur_x_r[31]}}, cur_x_r} + {dx[46], dx};
    ny     = {{16{cur_y_r[31]}}, cur_y_r} + {dy[46], dy};
    hd_sum = base + full_r + 32'h8000;
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        item_r <= q_item;
      end
      ST_W: begin
        w_r <= cfg.gear_ratio_q16 * cfg.wheel_radius_q16;
      end
      ST_C: begin
        c_r <= c_sum[53:32];
      end
      ST_L: begin
        lin_r <= lin_rs[31:0];
        dv_r  <= dv_rs[31:0];
      end
      ST_Y: begin
        yaw_r <= sat32({{7{yaw_rs[56]}}, yaw_rs});
      end
      ST_P1: begin
        div_num_r <= 72'(yaw_mag * item_r.dt + HALF_SEC_US);
        div_rem_r <= 20'd0;
        div_q_r   <= 44'd0;
        div_cnt_r <= 5'd0;
      end
      ST_D1, ST_D2: begin
        div_num_r <= div_num_nxt;
        div_rem_r <= div_rem_nxt;
        div_q_r   <= div_q_nxt;
        div_cnt_r <= div_cnt_r + 5'd1;
        if (div_cnt_r == 5'(DIV_CYCLES - 1)) begin
          if (state_r == ST_D1) begin
            m_r <= div_q_nxt;
          end else begin
            dist_r <= lin_r[31] ? -$signed({1'b0, div_q_nxt}) : $signed({1'b0, div_q_nxt});
          end
        end
      end
      ST_T: begin
        pa_r <= 24'(m_r[43:25] * INV_TWO_PI_Q32);
        pb_r <= m_r[24:0] * INV_TWO_PI_Q32;
      end
      ST_T2: begin
        full_r <= full_v;
        cx_r   <= CORDIC_GAIN_Q30;
        cy_r   <= 34'sd0;
        cnt_r  <= '0;
        if (z0 > 33'sd1073741824) begin
          cz_r   <= z0 - 33'sd2147483648;
          flip_r <= 1'b1;
        end else if (z0 < -33'sd1073741824) begin
          cz_r   <= z0 + 33'sd2147483648;
          flip_r <= 1'b1;
        end else begin
          cz_r   <= z0;
          flip_r <= 1'b0;
        end
      end
      ST_CR: begin
        if (!cz_r[32]) begin
          cx_r <= cx_r - dxs;
          cy_r <= cy_r + dys;
          cz_r <= cz_r - at;
        end else begin
          cx_r <= cx_r + dxs;
          cy_r <= cy_r - dys;
          cz_r <= cz_r + at;
        end
        cnt_r <= cnt_r + 1'b1;
      end
      ST_CF: begin
        co_r <= flip_r ? -xc : xc;
        si_r <= flip_r ? -yc : yc;
      end
      ST_P2: begin
        div_num_r <= 72'(lin_mag * item_r.dt + HALF_SEC_US);
        div_rem_r <= 20'd0;
        div_q_r   <= 44'd0;
        div_cnt_r <= 5'd0;
      end
      ST_M: begin
        dxp_r <= dist_r * co_r;
        dyp_r <= dist_r * si_r;
      end
      ST_U: begin
        if (out_free) begin
          out_data_r.fwd_speed <= lin_r;
          out_data_r.yaw_rate  <= yaw_r;
          out_data_r.pos_x     <= sat32({{16{nx[47]}}, nx});
          out_data_r.pos_y     <= sat32({{16{ny[47]}}, ny});
          out_data_r.heading   <= hd_sum[31:16];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cur_x_r     <= 32'sd0;
      cur_y_r     <= 32'sd0;
      cur_hd_r    <= 16'd0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (!q_empty) begin
            state_r <= ST_W;
          end
        end
        ST_W: begin
          if (item_r.first) begin
            cur_x_r  <= cfg.initial_x;
            cur_y_r  <= cfg.initial_y;
            cur_hd_r <= cfg.initial_heading;
          end
          state_r <= ST_C;
        end
        ST_C:  state_r <= ST_L;
        ST_L:  state_r <= ST_Y;
        ST_Y:  state_r <= ST_P1;
        ST_P1: state_r <= ST_D1;
        ST_D1: begin
          if (div_cnt_r == 5'(DIV_CYCLES - 1)) begin
            state_r <= ST_T;
          end
        end
        ST_T:  state_r <= ST_T2;
        ST_T2: state_r <= ST_CR;
        ST_CR: begin
          if (cnt_r == CNT_W'(CORDIC_STEPS - 1)) begin
            state_r <= ST_CF;
          end
        end
        ST_CF: state_r <= ST_P2;
        ST_P2: state_r <= ST_D2;
        ST_D2: begin
          if (div_cnt_r == 5'(DIV_CYCLES - 1)) begin
            state_r <= ST_M;
          end
        end
        ST_M:  state_r <= ST_U;
        ST_U: begin
          if (out_free) begin
            cur_x_r     <= sat32({{16{nx[47]}}, nx});
            cur_y_r     <= sat32({{16{ny[47]}}, ny});
            cur_hd_r    <= hd_sum[31:16];
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
